// ----- hdl/slt_pkg.sv -----
`timescale 1ns / 1ps

// Shared types and constants for the list table.
package slt_pkg;

  // Size of the list and widths of the item fields.
  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int FOUND_W  = 7;
  localparam int FILL_W   = 8;

  // Widths derived from the capacity.
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = IDX_W;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int POS_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Operation codes carried on the kind field.
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // What every cell does with its entry in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  // Control broadcast from the sequencer to the whole row of cells.
  typedef struct packed {
    logic             cmp_en;
    cell_op_e         op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  // One node of the first-match scan: any hit so far and its position.
  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] idx;
  } scan_node_t;

endpackage

// ----- hdl/slt_cell.sv -----
`timescale 1ns / 1ps

// One list slot: holds an entry, compares it against the search value and
// takes the new value at the insert point or a neighbor's entry when the list shifts.
module slt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [slt_pkg::IDX_W-1:0]  cell_idx_i,
  input  slt_pkg::cell_ctrl_t        ctrl_i,
  input  logic [slt_pkg::DATA_W-1:0] left_entry_i,
  input  logic [slt_pkg::DATA_W-1:0] right_entry_i,
  input  logic                       prefix_hit_i,
  output logic [slt_pkg::DATA_W-1:0] entry_o,
  output logic                       hit_o
);

  localparam int CntW = slt_pkg::CNT_W;
  localparam int PosW = slt_pkg::POS_W;

  logic [slt_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                       hit_q, hit_d;
  logic                       in_use;
  logic [PosW-1:0]            my_pos;

  assign in_use = (CntW'(cell_idx_i) < ctrl_i.count);
  assign my_pos = PosW'(cell_idx_i);

  // Match flag is captured when a transaction is accepted.
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      hit_d = in_use && (entry_q == ctrl_i.value);
    end
  end

  // Entries above the insert point move up, entries past the deleted one move down.
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      slt_pkg::CELL_INSERT: begin
        if (my_pos == ctrl_i.pos) begin
          entry_d = ctrl_i.value;
        end else if (my_pos > ctrl_i.pos) begin
          entry_d = left_entry_i;
        end
      end
      slt_pkg::CELL_DELETE: begin
        if (prefix_hit_i) begin
          entry_d = right_entry_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

// ----- hdl/slt_scan.sv -----
`timescale 1ns / 1ps

// First-match scan over the row of match flags. A log-depth prefix network
// is run one level per cycle on a single register row, so after LEVELS steps
// every node holds the first hit at or below its position.
module slt_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [slt_pkg::CAPACITY-1:0] hits_i,
  output logic [slt_pkg::CAPACITY-1:0] prefix_o,
  output slt_pkg::scan_node_t          root_o,
  output logic                         done_o
);

  localparam int Cap  = slt_pkg::CAPACITY;
  localparam int IdxW = slt_pkg::IDX_W;
  localparam int LvlW = slt_pkg::LVL_W;
  localparam logic [LvlW-1:0] LastLvl = LvlW'(slt_pkg::LEVELS - 1);

  slt_pkg::scan_node_t node_q [Cap];
  slt_pkg::scan_node_t node_d [Cap];
  logic [LvlW-1:0]     lvl_q;
  logic                busy_q;
  logic                done_q;

  // One prefix level: each node looks 2^level places down and keeps the earlier hit.
  always_comb begin
    slt_pkg::scan_node_t left;
    for (int i = 0; i < Cap; i++) begin
      left = '0;
      for (int k = 0; k < slt_pkg::LEVELS; k++) begin
        if ((lvl_q == LvlW'(k)) && (i >= (1 << k))) begin
          left = node_q[(i >= (1 << k)) ? (i - (1 << k)) : 0];
        end
      end
      if (start_i) begin
        node_d[i].any = hits_i[i];
        node_d[i].idx = IdxW'(i);
      end else if (busy_q && left.any) begin
        node_d[i] = left;
      end else begin
        node_d[i] = node_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Cap; i++) begin
      node_q[i] <= node_d[i];
    end
  end

  // Level counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        lvl_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (lvl_q == LastLvl) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          lvl_q <= lvl_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      prefix_o[i] = node_q[i].any;
    end
  end

  assign root_o = node_q[Cap-1];
  assign done_o = done_q;

endmodule

// ----- hdl/sequential_list_table_core.sv -----
`timescale 1ns / 1ps

// Find and delete: the accepted transaction passes the load, scan and apply states; the
// first-match scan runs one prefix level per cycle. Insert and unused codes go straight
// to the apply state. A new transaction is taken only in the idle state, so not before
// the last one is applied; apply waits while an earlier result is held and not taken. The
// output register lets a new transaction in while a result waits. Reset (asynchronous,
// active low) empties the list and clears control; entry contents are not reset.
module sequential_list_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [slt_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [slt_pkg::DATA_W-1:0] item_value_i,
  input  logic [slt_pkg::SLOT_W-1:0]        slot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              ok_o,
  output logic [slt_pkg::FOUND_W-1:0]       found_at_o,
  output logic [slt_pkg::FILL_W-1:0]        fill_o
);

  localparam int Cap  = slt_pkg::CAPACITY;
  localparam int DatW = slt_pkg::DATA_W;
  localparam int CntW = slt_pkg::CNT_W;
  localparam int PosW = slt_pkg::POS_W;
  localparam int CmpW = ((CntW > slt_pkg::SLOT_W) ? CntW : slt_pkg::SLOT_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e                          state_q;
  logic [slt_pkg::KIND_W-1:0]      kind_q;
  logic [DatW-1:0]                 value_q;
  logic [slt_pkg::SLOT_W-1:0]      slot_q;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            out_valid_q;
  logic                            ok_q, ok_d;
  logic [slt_pkg::FOUND_W-1:0]     found_q, found_d;
  logic [slt_pkg::FILL_W-1:0]      fill_q;

  logic                            in_fire;
  logic                            apply_fire;
  logic                            ins_ok;
  logic                            del_ok;
  logic                            find_ok;
  slt_pkg::cell_ctrl_t             ctrl;
  logic [DatW-1:0]                 entry [Cap];
  logic [Cap-1:0]                  hits;
  logic [Cap-1:0]                  prefix;
  slt_pkg::scan_node_t             root;
  logic                            scan_done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  // Legality of the pending operation.
  assign ins_ok  = (kind_q == slt_pkg::KIND_INSERT) && (slot_q != '0)
                && (CmpW'(slot_q) <= (CmpW'(count_q) + CmpW'(1)))
                && (CmpW'(count_q) < CmpW'(Cap));
  assign del_ok  = (kind_q == slt_pkg::KIND_DELETE) && root.any;
  assign find_ok = (kind_q == slt_pkg::KIND_FIND) && root.any;

  // Broadcast control to the row of cells.
  always_comb begin
    ctrl.cmp_en = in_fire;
    ctrl.value  = (state_q == ST_IDLE) ? DatW'(item_value_i) : value_q;
    ctrl.pos    = PosW'(slot_q) - PosW'(1);
    ctrl.count  = count_q;
    ctrl.op     = slt_pkg::CELL_HOLD;
    if (apply_fire && ins_ok) begin
      ctrl.op = slt_pkg::CELL_INSERT;
    end else if (apply_fire && del_ok) begin
      ctrl.op = slt_pkg::CELL_DELETE;
    end
  end

  // Row of cells, each wired to its neighbors; an end cell gets its own entry for the missing one.
  for (genvar gi = 0; gi < Cap; gi++) begin : g_cell
    slt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_idx_i    (slt_pkg::IDX_W'(gi)),
      .ctrl_i        (ctrl),
      .left_entry_i  (entry[(gi > 0) ? (gi - 1) : 0]),
      .right_entry_i (entry[(gi < Cap - 1) ? (gi + 1) : gi]),
      .prefix_hit_i  (prefix[gi]),
      .entry_o       (entry[gi]),
      .hit_o         (hits[gi])
    );
  end

  slt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_LOAD),
    .hits_i   (hits),
    .prefix_o (prefix),
    .root_o   (root),
    .done_o   (scan_done)
  );

  // Result and new fill level of the pending operation.
  always_comb begin
    count_d = count_q;
    ok_d    = 1'b0;
    found_d = '0;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
      ok_d    = 1'b1;
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
      ok_d    = 1'b1;
    end else if (find_ok) begin
      ok_d    = 1'b1;
      found_d = slt_pkg::FOUND_W'(root.idx);
    end
  end

  // Sequencer, fill count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= '0;
      value_q     <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= '0;
      fill_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            kind_q  <= kind_i;
            value_q <= DatW'(item_value_i);
            slot_q  <= slot_i;
            if ((kind_i == slt_pkg::KIND_FIND) || (kind_i == slt_pkg::KIND_DELETE)) begin
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_APPLY;
            end
          end
        end
        ST_LOAD: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply_fire) begin
            count_q     <= count_d;
            ok_q        <= ok_d;
            found_q     <= found_d;
            fill_q      <= slt_pkg::FILL_W'(count_d);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign found_at_o  = found_q;
  assign fill_o      = fill_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import slt_pkg::*;

  // The kind code that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1080;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 20;

  // Shapes of the random stimulus: fill the list, empty it, or mix.
  typedef enum logic [1:0] {
    MODE_GROW,
    MODE_SHRINK,
    MODE_CHURN
  } list_mode_e;

  // One list operation together with its sender timing.
  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot;
    int unsigned              gap;
    bit                       drain;
  } list_op_t;

  typedef struct packed {
    logic               ok;
    logic [FOUND_W-1:0] found_at;
    logic [FILL_W-1:0]  fill;
  } list_result_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [KIND_W-1:0]        kind_i       = '0;
  logic signed [DATA_W-1:0] item_value_i = '0;
  logic [SLOT_W-1:0]        slot_i       = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic                     ok_o;
  logic [FOUND_W-1:0]       found_at_o;
  logic [FILL_W-1:0]        fill_o;

  // Pending operations, the predicted contents and the results still owed.
  list_op_t                 pending_q[$];
  logic signed [DATA_W-1:0] model_list[$];
  logic signed [DATA_W-1:0] plan_list[$];
  list_result_t             expected_q[$];

  list_op_t    cur_item;
  bit          item_loaded = 1'b0;
  bit          presenting  = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt     = 0;
  int unsigned idle_cycles = 0;
  bit          stim_done   = 1'b0;
  bit          calm        = 1'b0;
  bit          drain_next  = 1'b0;

  sequential_list_table_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .item_value_i(item_value_i),
    .slot_i      (slot_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .found_at_o  (found_at_o),
    .fill_o      (fill_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Apply one operation to a list and return the result the block must give.
  function automatic list_result_t list_step(ref logic signed [DATA_W-1:0] lst[$],
                                             input list_op_t op);
    list_result_t r;
    int           hit;
    r   = '0;
    hit = -1;
    if (op.kind == KIND_FIND || op.kind == KIND_DELETE) begin
      foreach (lst[i]) begin
        if (hit < 0 && lst[i] == op.value) hit = i;
      end
    end
    case (op.kind)
      KIND_FIND: begin
        if (hit >= 0) begin
          r.ok       = 1'b1;
          r.found_at = FOUND_W'(hit);
        end
      end
      KIND_INSERT: begin
        if (op.slot >= 1 && op.slot <= lst.size() + 1 && lst.size() < CAPACITY) begin
          lst.insert(op.slot - 1, op.value);
          r.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (hit >= 0) begin
          lst.delete(hit);
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.fill = FILL_W'(lst.size());
    return r;
  endfunction

  // Queue an operation for the driver and track the list it will leave behind.
  function automatic void plan_op(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                                  logic [SLOT_W-1:0] slot);
    list_op_t     op;
    list_result_t unused;
    op.kind  = kind;
    op.value = value;
    op.slot  = slot;
    op.gap   = calm ? 0 : $urandom_range(0, 15);
    op.drain = drain_next;
    drain_next = 1'b0;
    pending_q.push_back(op);
    unused = list_step(plan_list, op);
  endfunction

  // Mostly a small set of values so that duplicates and hits are common.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return DATA_W'($urandom_range(0, 11)) - 4;
    if (r == 5) return {1'b1, {(DATA_W-1){1'b0}}};
    if (r == 6) return {1'b0, {(DATA_W-1){1'b1}}};
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_present();
    if (plan_list.size() > 0 && $urandom_range(0, 9) < 8)
      return plan_list[$urandom_range(0, plan_list.size() - 1)];
    return pick_value();
  endfunction

  function automatic logic [SLOT_W-1:0] pick_good_slot();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 1;
    if (r == 1) return SLOT_W'(plan_list.size() + 1);
    return SLOT_W'($urandom_range(1, plan_list.size() + 1));
  endfunction

  function automatic logic [SLOT_W-1:0] pick_bad_slot();
    if (plan_list.size() + 2 <= 255 && $urandom_range(0, 1) == 1)
      return SLOT_W'($urandom_range(plan_list.size() + 2, 255));
    return '0;
  endfunction

  // Stimulus: a directed opening, then phases of random operations.
  initial begin
    list_mode_e  mode;
    int unsigned counted;
    int unsigned phase_left;
    int unsigned phase_idx;
    int unsigned r;
    int unsigned t_ins, t_bad, t_fnd, t_del;

    // Misses and refusals on the empty list.
    plan_op(KIND_FIND,   5, 0);
    plan_op(KIND_DELETE, 5, 0);
    plan_op(KIND_INSERT, 1, 0);
    plan_op(KIND_INSERT, 1, 2);
    plan_op(KIND_INSERT, 1, 255);
    // Build a short list at the front, middle and end, with a duplicate.
    plan_op(KIND_INSERT, {1'b1, {(DATA_W-1){1'b0}}}, 1);
    plan_op(KIND_INSERT, {1'b0, {(DATA_W-1){1'b1}}}, 2);
    plan_op(KIND_INSERT, -1, 1);
    plan_op(KIND_INSERT, 0, 2);
    plan_op(KIND_INSERT, 7, 5);
    plan_op(KIND_INSERT, 7, 3);
    plan_op(KIND_INSERT, 3, 8);
    plan_op(KIND_INSERT, 3, 0);
    // Hits, a miss and the ignored code.
    plan_op(KIND_FIND, 7, 0);
    plan_op(KIND_FIND, {1'b1, {(DATA_W-1){1'b0}}}, 0);
    plan_op(KIND_FIND, {1'b0, {(DATA_W-1){1'b1}}}, 0);
    plan_op(KIND_FIND, 3, 0);
    plan_op(KIND_UNUSED, 7, 1);
    plan_op(KIND_UNUSED, -1, 255);
    // Delete the first of two equal entries, then the extremes.
    plan_op(KIND_DELETE, 7, 0);
    plan_op(KIND_FIND, 7, 0);
    plan_op(KIND_DELETE, 99, 0);
    plan_op(KIND_DELETE, {1'b1, {(DATA_W-1){1'b0}}}, 0);
    plan_op(KIND_DELETE, {1'b0, {(DATA_W-1){1'b1}}}, 0);

    // The first random operation waits for every outstanding result.
    drain_next = 1'b1;
    counted    = 0;
    phase_idx  = 0;
    phase_left = 0;
    mode       = MODE_GROW;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        // Fill to capacity first, then empty again, then mix freely.
        if (phase_idx == 0) begin
          mode       = MODE_GROW;
          phase_left = 220;
        end else if (phase_idx == 1) begin
          mode       = MODE_SHRINK;
          phase_left = 220;
        end else begin
          mode       = list_mode_e'($urandom_range(0, 2));
          phase_left = $urandom_range(40, 160);
          drain_next = ($urandom_range(0, 3) == 0);
        end
        calm = ($urandom_range(0, 3) == 0);
        phase_idx++;
      end
      case (mode)
        MODE_GROW: begin
          t_ins = 70; t_bad = 80; t_fnd = 90; t_del = 95;
        end
        MODE_SHRINK: begin
          t_ins = 10; t_bad = 15; t_fnd = 30; t_del = 95;
        end
        default: begin
          t_ins = 30; t_bad = 40; t_fnd = 65; t_del = 95;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < t_ins) begin
        plan_op(KIND_INSERT, pick_value(), pick_good_slot());
      end else if (r < t_bad) begin
        plan_op(KIND_INSERT, pick_value(), pick_bad_slot());
      end else if (r < t_fnd) begin
        plan_op(KIND_FIND, pick_present(), SLOT_W'($urandom));
      end else if (r < t_del) begin
        plan_op(KIND_DELETE, pick_present(), SLOT_W'($urandom));
      end else begin
        plan_op(KIND_UNUSED, $urandom, SLOT_W'($urandom));
      end
      if (r < t_del) counted++;
      phase_left--;
    end
    stim_done = 1'b1;
  end

  // Driver: present each pending operation after its gap and predict on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      item_loaded = 1'b0;
      presenting  = 1'b0;
      gap_left    = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(list_step(model_list, cur_item));
        item_loaded = 1'b0;
        presenting  = 1'b0;
      end
      if (!item_loaded && pending_q.size() > 0) begin
        cur_item     = pending_q.pop_front();
        gap_left     = cur_item.gap;
        item_loaded  = 1'b1;
        kind_i       <= cur_item.kind;
        item_value_i <= cur_item.value;
        slot_i       <= cur_item.slot;
      end
      // A draining operation holds back until no result is owed.
      if (item_loaded && !presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!cur_item.drain || expected_q.size() == 0) begin
          presenting = 1'b1;
        end
      end
      in_valid_i <= presenting;
    end
  end

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Monitor: check each result transaction and stall the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          exp_res = expected_q.pop_front();
          if (ok_o !== exp_res.ok)
            report_mismatch($sformatf("ok %0b, expected %0b", ok_o, exp_res.ok));
          if (found_at_o !== exp_res.found_at)
            report_mismatch($sformatf("found_at %0d, expected %0d",
                                      found_at_o, exp_res.found_at));
          if (fill_o !== exp_res.fill)
            report_mismatch($sformatf("fill %0d, expected %0d", fill_o, exp_res.fill));
        end
        results_seen++;
        // In each run of 128 results the receiver takes 32 without stalls.
        stall_left = (results_seen % 128 < 32) ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // End of run once all operations are taken and all results are back.
  initial begin
    @(posedge rst_ni);
    while (!stim_done || pending_q.size() > 0 || item_loaded || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
